// ===== sv/rse_pkg.sv =====
// shared constants, types and functions for the rgb sobel edge magnitude block
package rse_pkg;
	localparam int MaxWidthDefault = 4096;
	localparam int MaxHeight = 4096;
	localparam int PixW = 24;
	localparam logic [12:0] WidthReset = 13'd640;
	localparam logic [12:0] HeightReset = 13'd480;
	localparam logic [1:0] RegWidth = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam int SumW = 18;

	typedef struct packed {
		logic        valid;
		logic [11:0] col;
		logic [11:0] row;
		logic        last;
		logic        done;
	} rse_tag_t;

	// one channel of the 1,5,1 weighted gradients, squared, summed and saturated at 65536
	function automatic logic [SumW-1:0] sq_sum(input logic [7:0] l0, l1, l2, m0, m2,
			r0, r1, r2);
		logic signed [24:0] gx, gy;
		logic [24:0] s;
		begin
			gx = $signed({5'd0, l2}) - $signed({5'd0, l0})
				+ 13'sd5 * ($signed({5'd0, m2}) - $signed({5'd0, m0}))
				+ $signed({5'd0, r2}) - $signed({5'd0, r0});
			gy = $signed({5'd0, l0}) - $signed({5'd0, r0})
				+ 13'sd5 * ($signed({5'd0, l1}) - $signed({5'd0, r1}))
				+ $signed({5'd0, l2}) - $signed({5'd0, r2});
			s = 25'(gx * gx) + 25'(gy * gy);
			sq_sum = (s >= 25'd65536) ? 18'h10000 : {1'b0, s[16:0]};
		end
	endfunction
endpackage

// ===== sv/rse_ram.sv =====
// generic simple dual port ram with registered read
module rse_ram #(
	parameter int Width = 24,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
		if (we) mem_q[waddr] <= wdata;
	end
endmodule

// ===== sv/rse_root_cell.sv =====
// one cell of the square root chain: decides one result bit per cycle while en is high
module rse_root_cell #(
	parameter int Bit = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [3*rse_pkg::SumW-1:0] sum_in,
	input  logic [23:0]            root_in,
	input  rse_pkg::rse_tag_t      tag_in,
	output logic [3*rse_pkg::SumW-1:0] sum_out,
	output logic [23:0]            root_out,
	output rse_pkg::rse_tag_t      tag_out
);
	import rse_pkg::*;
	logic [23:0] root_d;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [7:0] t;
			logic [SumW-1:0] s;
			t = root_in[k*8 +: 8] | 8'(1 << Bit);
			s = sum_in[k*SumW +: SumW];
			if (s[SumW-1]) root_d[k*8 +: 8] = 8'hff;
			else if ({2'b0, {8'd0, t} * {8'd0, t}} <= s) root_d[k*8 +: 8] = t;
			else root_d[k*8 +: 8] = root_in[k*8 +: 8];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_out <= sum_in;
			root_out <= root_d;
		end
	end
endmodule

// ===== sv/rgb_sobel_edge_magnitude.sv =====
// top level of the rgb sobel edge magnitude block
// usage:
// pixels enter on the s_axis channel in raster order, tdata = {blue, green, red}
// (red lowest). every pixel gives zero, one or two result items on m_axis:
// an interior pixel (c,r) is sent when pixel (c+1,r+1) arrives, then a border
// pixel result of that same step, each with its coordinates. run_last marks the
// last item of a step, frame_done the last item of the frame.
// throughput: one pixel per cycle while m_axis does not stall and a step gives
// at most one result; a step with two results holds s_axis_tready low while its
// first item enters the root chain, as there is a single output port.
// pipeline: a line-store read stage, a window stage, a sum stage, then eight
// root cells, one result bit each, then the output register that drives tvalid.
// the stages before the root chain also hold for a two-item step; when m_axis
// stalls, everything holds and s_axis_tready drops, so no item is ever lost.
// reset clears counters, window and pipeline valid bits; line stores are not
// cleared since no result ever depends on unwritten entries.
// an apb write to frame_width or frame_height restarts the frame; write only
// while idle.
module rgb_sobel_edge_magnitude #(
	parameter int MaxWidth = rse_pkg::MaxWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pix_red, pix_green, pix_blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_col, out_row, edge_red, edge_green, edge_blue
	output logic        m_axis_tlast,  // run_last
	output logic [0:0]  m_axis_tuser   // frame_done
);
	import rse_pkg::*;
	localparam int AW = $clog2(MaxWidth);
	localparam int CW = $clog2(MaxWidth + 1);
	localparam logic [2:0] AddrWidth = {RegWidth[0], 2'b00};
	localparam logic [2:0] AddrHeight = {RegHeight[0], 2'b00};

	logic [12:0] width_q, height_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr[2])
			RegWidth[0]: prdata = {19'd0, width_q};
			default:     prdata = {19'd0, height_q};
		endcase
		if (paddr[1:0] != 2'b00) prdata = '0;
	end

	// effective frame size
	logic [CW-1:0] eff_w;
	logic [12:0] eff_h;
	always_comb begin
		if (width_q == 13'd0) eff_w = CW'(1);
		else if ({19'd0, width_q} > 32'(MaxWidth)) eff_w = CW'(MaxWidth);
		else eff_w = CW'(width_q);
		if (height_q == 13'd0) eff_h = 13'd1;
		else if (height_q > 13'(MaxHeight)) eff_h = 13'(MaxHeight);
		else eff_h = height_q;
	end

	// pipeline control: stages advance together, but the stages before the root chain hold in a two-item step
	logic adv, out_busy;
	logic [CW-1:0] col_q;
	logic [12:0] row_q;

	// stage 1: pixel accepted, line store read issued
	logic v_s1, v_s2, v_s3;
	logic [23:0] pix_s1, pix_s2;
	logic [CW-1:0] col_s1, col_s2;
	logic [12:0] row_s1, row_s2;
	logic [23:0] older_rd, prev_rd;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = adv;

	// the read in stage 1 of column c can collide with the write of stage 1 in the
	// same cycle only for width 1; resolve reads through bypass of the write data
	logic [23:0] prev_fwd, prev_s1v, older_s1v;
	logic [23:0] prev_hold_q, older_hold_q;
	logic rd_fresh_q, same_q;
	logic [23:0] prev_s2;

	rse_ram #(.Width(PixW), .Depth(MaxWidth)) u_prev (
		.clk(clk), .we(v_s1 && adv), .waddr(col_s1[AW-1:0]), .wdata(pix_s1),
		.re(acc), .raddr(col_q[AW-1:0]), .rdata(prev_rd));
	rse_ram #(.Width(PixW), .Depth(MaxWidth)) u_older (
		.clk(clk), .we(v_s1 && adv), .waddr(col_s1[AW-1:0]), .wdata(prev_fwd),
		.re(acc), .raddr(col_q[AW-1:0]), .rdata(older_rd));

	// read data is used the cycle after the read, or from hold registers loaded on a stall
	always_comb begin
		prev_s1v  = rd_fresh_q ? prev_rd : prev_hold_q;
		older_s1v = rd_fresh_q ? older_rd : older_hold_q;
		if (same_q) begin
			prev_s1v = pix_s2;
			older_s1v = prev_s2;
		end
	end
	assign prev_fwd = prev_s1v;

	logic [23:0] win_q [6];
	logic [23:0] l_s2 [3], m_s2 [3], r_s2 [3];
	logic int_s2, bord_s2, last_frame_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WidthReset;
			height_q <= HeightReset;
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rd_fresh_q <= 1'b0;
			same_q <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else begin
			rd_fresh_q <= acc;
			if (cfg_wr && paddr == AddrWidth) width_q <= pwdata[12:0];
			if (cfg_wr && paddr == AddrHeight) height_q <= pwdata[12:0];
			if (cfg_wr && (paddr == AddrWidth || paddr == AddrHeight)) begin
				col_q <= '0;
				row_q <= '0;
				for (int i = 0; i < 6; i++) win_q[i] <= '0;
			end else if (adv) begin
				v_s1 <= acc;
				v_s2 <= v_s1;
				same_q <= acc && v_s1 && col_s1 == col_q;
				if (acc) begin
					if (col_q + CW'(1) >= eff_w) begin
						col_q <= '0;
						row_q <= (row_q + 13'd1 >= eff_h) ? 13'd0 : row_q + 13'd1;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				if (v_s1) begin
					win_q[0] <= win_q[3];
					win_q[1] <= win_q[4];
					win_q[2] <= win_q[5];
					win_q[3] <= older_s1v;
					win_q[4] <= prev_s1v;
					win_q[5] <= pix_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fresh_q && !adv) begin
			prev_hold_q <= prev_rd;
			older_hold_q <= older_rd;
		end
		if (adv && acc) begin
			pix_s1 <= s_axis_tdata;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
		if (adv && v_s1) begin
			pix_s2 <= pix_s1;
			prev_s2 <= prev_s1v;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			for (int i = 0; i < 3; i++) begin
				l_s2[i] <= win_q[i];
				m_s2[i] <= win_q[3+i];
			end
			r_s2[0] <= older_s1v;
			r_s2[1] <= prev_s1v;
			r_s2[2] <= pix_s1;
			int_s2 <= col_s1 >= CW'(2) && row_s1 >= 13'd2;
			bord_s2 <= col_s1 == '0 || col_s1 == eff_w - CW'(1) || row_s1 == '0
				|| row_s1 == eff_h - 13'd1;
			last_frame_s2 <= col_s1 == eff_w - CW'(1) && row_s1 == eff_h - 13'd1;
		end
	end

	// stage 3: squared sums, then split into up to two items
	logic [3*SumW-1:0] sum_s3;
	logic int_s3, bord_s3, lf_s3;
	logic [11:0] col_s3, row_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			for (int k = 0; k < 3; k++) begin
				sum_s3[(2-k)*SumW +: SumW] <= sq_sum(l_s2[0][k*8 +: 8], l_s2[1][k*8 +: 8],
					l_s2[2][k*8 +: 8], m_s2[0][k*8 +: 8], m_s2[2][k*8 +: 8],
					r_s2[0][k*8 +: 8], r_s2[1][k*8 +: 8], r_s2[2][k*8 +: 8]);
			end
			int_s3 <= int_s2;
			bord_s3 <= bord_s2;
			lf_s3 <= last_frame_s2;
			col_s3 <= col_s2[11:0];
			row_s3 <= row_s2[11:0];
		end
	end

	// two-item steps: interior item first, then the border item
	logic second_q;
	logic both;
	rse_tag_t tag_in;
	assign both = v_s3 && int_s3 && bord_s3;
	always_comb begin
		tag_in = '0;
		if (v_s3 && int_s3 && !second_q) begin
			tag_in.valid = 1'b1;
			tag_in.col = col_s3 - 12'd1;
			tag_in.row = row_s3 - 12'd1;
			tag_in.last = !bord_s3;
			tag_in.done = !bord_s3 && lf_s3;
		end else if (v_s3 && bord_s3) begin
			tag_in.valid = 1'b1;
			tag_in.col = col_s3;
			tag_in.row = row_s3;
			tag_in.last = 1'b1;
			tag_in.done = lf_s3;
		end
	end

	logic chain_en;
	assign chain_en = !out_busy;
	// a border item has a zero sum
	logic [3*SumW-1:0] sum_in;
	assign sum_in = (v_s3 && int_s3 && !second_q) ? sum_s3 : '0;
	assign adv = chain_en && !(both && !second_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) second_q <= 1'b0;
		else if (chain_en) second_q <= both && !second_q;
	end

	// square root chain: eight cells, msb first
	logic [3*SumW-1:0] sums [9];
	logic [23:0] roots [9];
	rse_tag_t tags [9];
	assign sums[0] = sum_in;
	assign roots[0] = '0;
	assign tags[0] = tag_in;
	for (genvar g = 0; g < 8; g++) begin : g_cell
		rse_root_cell #(.Bit(7 - g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(chain_en),
			.sum_in(sums[g]), .root_in(roots[g]), .tag_in(tags[g]),
			.sum_out(sums[g+1]), .root_out(roots[g+1]), .tag_out(tags[g+1]));
	end

	// output register
	assign out_busy = m_axis_tvalid && !m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (!out_busy) begin
			m_axis_tvalid <= tags[8].valid;
		end
	end
	always_ff @(posedge clk) begin
		if (!out_busy) begin
			m_axis_tdata <= {roots[8][7:0], roots[8][15:8], roots[8][23:16],
				tags[8].row, tags[8].col};
			m_axis_tlast <= tags[8].last;
			m_axis_tuser <= tags[8].done;
		end
	end
endmodule

// ===== sv/rse_checker.sv =====
// port-level checks for the rgb sobel edge magnitude block
module rse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser,
	input logic        s_axis_tready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("frame end without run end");
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
endmodule

bind rgb_sobel_edge_magnitude rse_checker u_rse_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
	.s_axis_tready(s_axis_tready));
